// ===== hw/rtl/pct_pkg.sv =====
// Package for the polygon convexity test.
// Holds the coordinate width, the vertex count limits and the turn sign function.
// Depends on nothing.
package pct_pkg;

    localparam int COORD_BITS = 16;
    localparam int CNT_BITS   = 3;

    localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] CNT_TWO  = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0] CNT_WRAP = CNT_BITS'(3);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_turn;

    // Sign of the cross product (b - a) x (c - a), computed exactly.
    function automatic t_turn f_turn(
        input t_coord ax,
        input t_coord ay,
        input t_coord bx,
        input t_coord by,
        input t_coord cx,
        input t_coord cy
    );
        logic signed [COORD_BITS:0]     ux;
        logic signed [COORD_BITS:0]     uy;
        logic signed [COORD_BITS:0]     wx;
        logic signed [COORD_BITS:0]     wy;
        logic signed [2*COORD_BITS+1:0] p1;
        logic signed [2*COORD_BITS+1:0] p2;
        logic signed [2*COORD_BITS+2:0] d;
        t_turn                          t;
        ux = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
        uy = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
        wx = {cx[COORD_BITS-1], cx} - {ax[COORD_BITS-1], ax};
        wy = {cy[COORD_BITS-1], cy} - {ay[COORD_BITS-1], ay};
        p1 = ux * wy;
        p2 = uy * wx;
        d  = {p1[2*COORD_BITS+1], p1} - {p2[2*COORD_BITS+1], p2};
        t.neg = d[2*COORD_BITS+2];
        t.pos = !d[2*COORD_BITS+2] && (d != '0);
        return t;
    endfunction

endpackage

// ===== hw/rtl/polygon_convexity_test_top.sv =====
// Polygon convexity test: one vertex item per cycle, one result item on the last vertex.
// The last vertex passes the input register, then the result is set in the result register.
// Throughput: one vertex item per cycle unless a last vertex waits on a stalled result;
// the cross products of one item are combinational between the input and result registers.
// Reset: synchronous, active low; clears the vertex history, turn flags and valid bits.
// Depends on pct_pkg.
module polygon_convexity_test_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [pct_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic [pct_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic                   i_final_vertex,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_convex
);
    import pct_pkg::*;

    t_coord               r_first_x, r_first_y, r_second_x, r_second_y;
    t_coord               r_older_x, r_older_y, r_recent_x, r_recent_y;
    logic [CNT_BITS-1:0]  r_cnt;

    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic                 r_s1_two;
    logic                 r_s1_wrap;
    t_coord               r_s1_nx, r_s1_ny, r_s1_ox, r_s1_oy, r_s1_rx, r_s1_ry;
    t_coord               r_s1_fx, r_s1_fy, r_s1_tx, r_s1_ty;

    logic                 r_left, r_right;
    logic                 r_out_valid;
    logic                 r_convex;

    logic                 s1_go;
    logic                 in_acc;
    t_turn                turn0, turn1, turn2;
    logic                 n_left, n_right;
    logic                 n_convex;

    assign s1_go   = r_s1_valid && (!r_s1_last || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_second_x <= '0;
            r_second_y <= '0;
            r_older_x <= '0;
            r_older_y <= '0;
            r_recent_x <= '0;
            r_recent_y <= '0;
        end else if (in_acc) begin
            if (i_final_vertex) begin
                r_cnt <= '0;
                r_first_x <= '0;
                r_first_y <= '0;
                r_second_x <= '0;
                r_second_y <= '0;
                r_older_x <= '0;
                r_older_y <= '0;
                r_recent_x <= '0;
                r_recent_y <= '0;
            end else begin
                if (r_cnt == '0) begin
                    r_first_x <= i_vertex_x;
                    r_first_y <= i_vertex_y;
                end
                if (r_cnt == CNT_BITS'(1)) begin
                    r_second_x <= i_vertex_x;
                    r_second_y <= i_vertex_y;
                end
                r_older_x <= r_recent_x;
                r_older_y <= r_recent_y;
                r_recent_x <= i_vertex_x;
                r_recent_y <= i_vertex_y;
                if (r_cnt < CNT_MAX) begin
                    r_cnt <= r_cnt + CNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_last <= i_final_vertex;
            r_s1_two  <= (r_cnt >= CNT_TWO);
            r_s1_wrap <= (r_cnt >= CNT_WRAP);
            r_s1_nx   <= i_vertex_x;
            r_s1_ny   <= i_vertex_y;
            r_s1_ox   <= r_older_x;
            r_s1_oy   <= r_older_y;
            r_s1_rx   <= r_recent_x;
            r_s1_ry   <= r_recent_y;
            r_s1_fx   <= r_first_x;
            r_s1_fy   <= r_first_y;
            r_s1_tx   <= r_second_x;
            r_s1_ty   <= r_second_y;
        end
    end

    always_comb begin
        turn0 = f_turn(r_s1_ox, r_s1_oy, r_s1_rx, r_s1_ry, r_s1_nx, r_s1_ny);
        turn1 = f_turn(r_s1_rx, r_s1_ry, r_s1_nx, r_s1_ny, r_s1_fx, r_s1_fy);
        turn2 = f_turn(r_s1_nx, r_s1_ny, r_s1_fx, r_s1_fy, r_s1_tx, r_s1_ty);
        n_left   = r_left;
        n_right  = r_right;
        n_convex = 1'b1;
        if (r_s1_last) begin
            if (r_s1_wrap) begin
                n_convex = !((r_left || turn0.pos || turn1.pos || turn2.pos) &&
                             (r_right || turn0.neg || turn1.neg || turn2.neg));
            end
            n_left  = 1'b0;
            n_right = 1'b0;
        end else if (r_s1_two) begin
            n_left  = r_left || turn0.pos;
            n_right = r_right || turn0.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_left  <= n_left;
                r_right <= n_right;
            end
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_convex <= n_convex;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_convex = r_convex;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("vertex count above its limit");

    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_final_vertex) |=> (r_cnt == '0))
        else $error("vertex history not cleared after the last vertex");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result item without a last vertex");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_last && r_out_valid && i_stall))
        else $error("input stalled without a blocked result");

endmodule

// ===== tb/sv/polygon_convexity_test_top_tb.sv =====
// Self-checking testbench for the streaming polygon convexity test.
// Vertex items are driven with random gaps and output stalls, and each convex flag is checked
// against a cycle-free predictor held in a small scoreboard. Depends on pct_pkg and the top.
`timescale 1ns / 100ps

module polygon_convexity_test_top_tb;

    import pct_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;

    class convexity_scoreboard;
        localparam int COUNT_SAT = 4;

        t_coord      first_x, first_y, second_x, second_y;
        t_coord      older_x, older_y, recent_x, recent_y;
        int unsigned seen_count;
        bit          saw_left, saw_right;
        bit          convex_q[$];
        int unsigned errors;

        function new();
            errors = 0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            first_x = '0;
            first_y = '0;
            second_x = '0;
            second_y = '0;
            older_x = '0;
            older_y = '0;
            recent_x = '0;
            recent_y = '0;
            seen_count = 0;
            saw_left = 1'b0;
            saw_right = 1'b0;
        endfunction

        // The sign of (b - a) x (c - a); 64-bit arithmetic keeps it exact.
        static function int turn_sign(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                      t_coord cx, t_coord cy);
            longint ux, uy, wx, wy, d;
            ux = longint'(bx) - longint'(ax);
            uy = longint'(by) - longint'(ay);
            wx = longint'(cx) - longint'(ax);
            wy = longint'(cy) - longint'(ay);
            d = ux * wy - uy * wx;
            return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
        endfunction

        function void note_turn(int sgn);
            if (sgn > 0) begin
                saw_left = 1'b1;
            end else if (sgn < 0) begin
                saw_right = 1'b1;
            end
        endfunction

        function void note_vertex(t_coord x, t_coord y, bit fin);
            bit verdict;
            if (!fin) begin
                if (seen_count >= 2) begin
                    note_turn(turn_sign(older_x, older_y, recent_x, recent_y, x, y));
                end
                if (seen_count == 0) begin
                    first_x = x;
                    first_y = y;
                end else if (seen_count == 1) begin
                    second_x = x;
                    second_y = y;
                end
                older_x = recent_x;
                older_y = recent_y;
                recent_x = x;
                recent_y = y;
                if (seen_count < COUNT_SAT) begin
                    seen_count++;
                end
            end else begin
                verdict = 1'b1;
                if (seen_count >= 3) begin
                    note_turn(turn_sign(older_x, older_y, recent_x, recent_y, x, y));
                    note_turn(turn_sign(recent_x, recent_y, x, y, first_x, first_y));
                    note_turn(turn_sign(x, y, first_x, first_y, second_x, second_y));
                    verdict = !(saw_left && saw_right);
                end
                convex_q.push_back(verdict);
                clear_polygon();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endtask

        task check_result(logic convex);
            bit want;
            if (convex_q.size() == 0) begin
                report($sformatf("result convex=%b with no polygon outstanding", convex));
            end else begin
                want = convex_q.pop_front();
                if (convex !== want) begin
                    report($sformatf("convex got %b, want %b", convex, want));
                end
            end
        endtask
    endclass

    logic   clk;
    logic   rst_n = 1'b0;
    logic   vtx_valid = 1'b0;
    logic   vtx_stall;
    logic   [COORD_BITS-1:0] vtx_x = '0;
    logic   [COORD_BITS-1:0] vtx_y = '0;
    logic   vtx_final = 1'b0;
    logic   res_valid;
    logic   res_stall = 1'b0;
    logic   res_convex;

    bit     send_idle = 1'b1;
    bit     recv_idle = 1'b1;
    bit     hold_request = 1'b0;
    int     sent_items = 0;
    t_coord poly_x[$];
    t_coord poly_y[$];
    int     dir_x [16] = '{4, 4, 3, 2, 0, -2, -3, -4, -4, -4, -3, -2, 0, 2, 3, 4};
    int     dir_y [16] = '{0, 2, 3, 4, 4, 4, 3, 2, 0, -2, -3, -4, -4, -4, -3, -2};

    convexity_scoreboard sb = new();

    polygon_convexity_test_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (vtx_valid),
        .o_stall        (vtx_stall),
        .i_vertex_x     (vtx_x),
        .i_vertex_y     (vtx_y),
        .i_final_vertex (vtx_final),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_convex       (res_convex)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && vtx_valid && !vtx_stall) begin
            sb.note_vertex(vtx_x, vtx_y, vtx_final);
        end
        if (rst_n && res_valid && !res_stall) begin
            sb.check_result(res_convex);
        end
    end

    initial begin : receiver
        int hold;
        forever begin
            hold = recv_idle ? $urandom_range(0, 6) : 0;
            if (hold_request) begin
                hold += LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("polygon_convexity_test_top: mismatch");
        $finish;
    end

    task automatic send_vertex(input t_coord x, input t_coord y, input logic fin);
        int gap;
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            vtx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_x <= x;
        vtx_y <= y;
        vtx_final <= fin;
        do @(posedge clk); while (vtx_stall !== 1'b0);
    endtask

    task automatic add_vertex(input int x, input int y);
        poly_x.push_back(t_coord'(x));
        poly_y.push_back(t_coord'(y));
    endtask

    task automatic send_polygon();
        int k;
        for (k = 0; k < poly_x.size(); k++) begin
            send_vertex(poly_x[k], poly_y[k], k == poly_x.size() - 1);
        end
        sent_items += poly_x.size();
        poly_x.delete();
        poly_y.delete();
    endtask

    task automatic drain_results();
        vtx_valid <= 1'b0;
        do @(posedge clk); while (sb.convex_q.size() != 0);
    endtask

    task automatic make_polygon();
        int kind, n, k, idx, scale, span, cx, cy, start, rev, keep_pct, dx, dy;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            scale = $urandom_range(1, 8000);
            span = 32767 - 4 * scale;
            cx = int'($urandom_range(0, 2 * span)) - span;
            cy = int'($urandom_range(0, 2 * span)) - span;
            start = $urandom_range(0, 15);
            rev = $urandom_range(0, 1);
            keep_pct = $urandom_range(15, 100);
            for (k = 0; k < 16; k++) begin
                idx = rev ? ((start - k) & 15) : ((start + k) & 15);
                if ($urandom_range(1, 100) <= keep_pct) begin
                    add_vertex(cx + dir_x[idx] * scale, cy + dir_y[idx] * scale);
                end
            end
            if (poly_x.size() == 0) begin
                add_vertex(cx, cy);
            end
            if (kind >= 50) begin
                idx = $urandom_range(0, poly_x.size() - 1);
                if ($urandom_range(0, 1)) begin
                    poly_x[idx] = t_coord'(cx);
                    poly_y[idx] = t_coord'(cy);
                end else begin
                    poly_x[idx] = t_coord'($urandom);
                    poly_y[idx] = t_coord'($urandom);
                end
            end
        end else if (kind < 80) begin
            n = $urandom_range(1, 10);
            dx = int'($urandom_range(0, 16)) - 8;
            dy = int'($urandom_range(0, 16)) - 8;
            cx = int'($urandom_range(0, 40000)) - 20000;
            cy = int'($urandom_range(0, 40000)) - 20000;
            for (k = 0; k < n; k++) begin
                idx = int'($urandom_range(0, 2000)) - 1000;
                add_vertex(cx + idx * dx, cy + idx * dy);
            end
        end else begin
            n = (kind < 95) ? $urandom_range(1, 10) : $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                poly_x.push_back(t_coord'($urandom));
                poly_y.push_back(t_coord'($urandom));
            end
            if (n > 1 && $urandom_range(0, 1)) begin
                poly_x[n - 1] = poly_x[0];
                poly_y[n - 1] = poly_y[0];
            end
        end
    endtask

    initial begin : stimulus
        bit hold_done, drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_vertex(-32768, 32767);
        send_polygon();
        add_vertex(32767, 32767);
        add_vertex(-32768, -32768);
        send_polygon();
        add_vertex(0, 0);
        add_vertex(32767, -32768);
        add_vertex(-32768, 32767);
        send_polygon();
        add_vertex(-32768, -32768);
        add_vertex(32767, -32768);
        add_vertex(32767, 32767);
        add_vertex(-32768, 32767);
        send_polygon();
        add_vertex(0, 0);
        add_vertex(10, 0);
        add_vertex(3, 3);
        add_vertex(0, 10);
        send_polygon();
        add_vertex(-5, -5);
        add_vertex(0, 0);
        add_vertex(5, 5);
        add_vertex(32767, 32767);
        send_polygon();
        add_vertex(0, 0);
        add_vertex(0, 0);
        add_vertex(4, 0);
        add_vertex(4, 4);
        add_vertex(0, 4);
        send_polygon();

        while (sent_items < ITEM_TARGET) begin
            if (!hold_done && sent_items >= 400) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && sent_items >= 900) begin
                drain_results();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_idle = !send_idle;
            end
            if ($urandom_range(0, 9) == 0) begin
                recv_idle = !recv_idle;
            end
            make_polygon();
            send_polygon();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.convex_q.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.convex_q.size()));
        end
        if (sb.errors == 0) begin
            $display("polygon_convexity_test_top: match");
        end else begin
            $display("polygon_convexity_test_top: mismatch");
        end
        $finish;
    end

endmodule
